// ===== src/svma_pkg.sv =====
// Shared types, codes and arithmetic helpers of the stereo voice mix accumulator.
// No dependencies; imported by stereo_voice_mix_accumulator.
package svma_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] vtype_t;
    typedef logic [1:0] cfg_idx_t;

    localparam mode_t MODE_CLEAR = 2'd0;
    localparam mode_t MODE_ACCUM = 2'd1;
    localparam mode_t MODE_EMIT  = 2'd2;

    localparam vtype_t VTYPE_MUSIC   = 2'd0;
    localparam vtype_t VTYPE_EFFECTS = 2'd1;
    localparam vtype_t VTYPE_UI      = 2'd2;

    localparam cfg_idx_t CFG_MASTER  = 2'd0;
    localparam cfg_idx_t CFG_MUSIC   = 2'd1;
    localparam cfg_idx_t CFG_EFFECTS = 2'd2;
    localparam cfg_idx_t CFG_UI      = 2'd3;

    localparam logic [15:0] GAIN_UNITY = 16'h8000;

    // Clamp a sign-extended 64-bit value to int32
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sh0000_0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    // Q.14 entry to int16: round half to even, then clamp
    function automatic logic signed [15:0] round_emit(input logic signed [31:0] e);
        logic signed [17:0] q;
        logic        [13:0] rem;
        logic               up;
        logic signed [18:0] qr;
        logic signed [15:0] r;
        q   = e[31:14];
        rem = e[13:0];
        up  = (rem > 14'd8192) || ((rem == 14'd8192) && q[0]);
        qr  = 19'(q) + $signed({18'd0, up});
        if (qr > 19'sd32767)
            r = 16'sh7FFF;
        else if (qr < -19'sd32768)
            r = -16'sh8000;
        else
            r = qr[15:0];
        return r;
    endfunction

endpackage

// ===== src/stereo_voice_mix_accumulator.sv =====
// Stereo voice mix accumulator: ramped, gain-scaled voice samples summed into a
// frame of Q.14 entries held in two on-chip memories. Depends on svma_pkg.
//
//  channel   signals                                      direction  handshake
//  command   start, busy, mode, dest_index, sample_*,     in         start && !busy
//            voice_type, vol_start_*, vol_step_*
//  result    out_valid, out_index, out_left, out_right    out        strobe, one cycle
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data    in         valid && ready
//
// One command per cycle while busy is low. An emit reaches the result port through
// stages s1 to s6 and the output register; the depth is set by the three chained
// multiplies (index*step, ramp*gain, vol*sample). After reset busy stays high while
// a clearing pass zeroes the mix memories one entry per cycle; then busy stays low.
// Accumulates to the same entry back to back are handled by forwarding the last
// memory write. Results cannot be held off by the receiver.
module stereo_voice_mix_accumulator #(
    parameter int FRAME_LENGTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  svma_pkg::mode_t           mode,
    input  logic               [9:0]  dest_index,
    input  logic signed        [15:0] sample_left,
    input  logic signed        [15:0] sample_right,
    input  svma_pkg::vtype_t          voice_type,
    input  logic               [30:0] vol_start_left,
    input  logic               [30:0] vol_start_right,
    input  logic signed        [31:0] vol_step_left,
    input  logic signed        [31:0] vol_step_right,
    output logic                      out_valid,
    output logic               [9:0]  out_index,
    output logic signed        [15:0] out_left,
    output logic signed        [15:0] out_right,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  svma_pkg::cfg_idx_t        cfg_index,
    input  logic               [15:0] cfg_data
);
    import svma_pkg::*;

    // dest_index is 10 bits, so no more than 1024 entries are reachable
    localparam int DEPTH = (FRAME_LENGTH < 1024) ? FRAME_LENGTH : 1024;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [15:0] master_reg, music_reg, effects_reg, ui_reg;

    // clearing pass
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    // pipeline control
    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic          s6_valid_reg;
    mode_t         s1_mode_reg, s2_mode_reg, s3_mode_reg, s4_mode_reg, s5_mode_reg;
    logic [AW-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg, s5_idx_reg, s6_idx_reg;

    // pipeline data, index 0 left, 1 right
    logic signed [15:0] s1_smp_reg [2];
    logic signed [15:0] s2_smp_reg [2];
    logic signed [15:0] s3_smp_reg [2];
    logic signed [15:0] s4_smp_reg [2];
    logic        [30:0] s1_start_reg [2];
    logic signed [42:0] s1_sprod_reg [2];
    logic        [31:0] s1_gain_reg, s2_gain_reg;
    logic signed [31:0] s2_ramp_reg [2];
    logic signed [64:0] s3_vprod_reg [2];
    logic signed [31:0] s4_vol_reg [2];
    logic signed [47:0] s5_cprod_reg [2];
    logic signed [31:0] s6_entry_reg [2];

    // memories and forwarding
    logic signed [31:0] mix_l_mem [DEPTH];
    logic signed [31:0] mix_r_mem [DEPTH];
    logic signed [31:0] mem_q_reg [2];
    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic signed [31:0] fwd_data_reg [2];

    // result
    logic               out_valid_reg;
    logic [9:0]         out_index_reg;
    logic signed [15:0] out_left_reg, out_right_reg;

    // combinational
    logic               accept;
    logic               cmd_ok;
    logic [15:0]        type_gain;
    logic signed [42:0] sprod_next [2];
    logic [31:0]        gain_next;
    logic signed [31:0] ramp_next [2];
    logic signed [64:0] vprod_next [2];
    logic signed [31:0] vol_next [2];
    logic signed [47:0] cprod_next [2];
    logic signed [31:0] old_entry [2];
    logic signed [31:0] new_entry [2];
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data [2];
    logic signed [30:0] start_l, start_r;

    assign busy      = clearing_reg;
    assign cfg_ready = 1'b1;
    assign accept    = start && !clearing_reg;
    assign cmd_ok    = (32'(dest_index) < FRAME_LENGTH) &&
                       (mode == MODE_CLEAR || mode == MODE_ACCUM || mode == MODE_EMIT);

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    assign start_l = $signed(vol_start_left);
    assign start_r = $signed(vol_start_right);

    always_comb
    begin
        case (voice_type)
            VTYPE_MUSIC:   type_gain = music_reg;
            VTYPE_EFFECTS: type_gain = effects_reg;
            VTYPE_UI:      type_gain = ui_reg;
            default:       type_gain = 16'd0;
        endcase
        gain_next = master_reg * type_gain;
        sprod_next[0] = $signed({1'b0, dest_index}) * vol_step_left;
        sprod_next[1] = $signed({1'b0, dest_index}) * vol_step_right;
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            ramp_next[c]  = sat32(64'($signed({12'd0, s1_start_reg[c]}) +
                                      44'(s1_sprod_reg[c])));
            vprod_next[c] = s2_ramp_reg[c] * $signed({1'b0, s2_gain_reg});
            vol_next[c]   = sat32(64'(s3_vprod_reg[c] >>> 30));
            cprod_next[c] = s4_vol_reg[c] * s4_smp_reg[c];
            old_entry[c]  = (fwd_valid_reg && fwd_addr_reg == s5_idx_reg) ?
                            fwd_data_reg[c] : mem_q_reg[c];
            new_entry[c]  = sat32(64'(old_entry[c]) +
                                  64'($signed(s5_cprod_reg[c][47:16])));
        end
    end

    always_comb
    begin
        wr_en   = clearing_reg ||
                  (s5_valid_reg && (s5_mode_reg == MODE_CLEAR || s5_mode_reg == MODE_ACCUM));
        wr_addr = clearing_reg ? clr_addr_reg : s5_idx_reg;
        for (int c = 0; c < 2; c++)
            wr_data[c] = (clearing_reg || s5_mode_reg == MODE_CLEAR) ? 32'sd0 : new_entry[c];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg    <= GAIN_UNITY;
            music_reg     <= GAIN_UNITY;
            effects_reg   <= GAIN_UNITY;
            ui_reg        <= GAIN_UNITY;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MASTER:  master_reg  <= cfg_data;
                    CFG_MUSIC:   music_reg   <= cfg_data;
                    CFG_EFFECTS: effects_reg <= cfg_data;
                    CFG_UI:      ui_reg      <= cfg_data;
                    default:     ;
                endcase
            end
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                    clearing_reg <= 1'b0;
            end
            s1_valid_reg  <= accept && cmd_ok;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg && s5_mode_reg == MODE_EMIT;
            fwd_valid_reg <= !clearing_reg && wr_en;
            out_valid_reg <= s6_valid_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        s1_mode_reg     <= mode;
        s1_idx_reg      <= dest_index[AW-1:0];
        s1_smp_reg[0]   <= sample_left;
        s1_smp_reg[1]   <= sample_right;
        s1_start_reg[0] <= start_l;
        s1_start_reg[1] <= start_r;
        s1_sprod_reg    <= sprod_next;
        s1_gain_reg     <= gain_next;

        s2_mode_reg  <= s1_mode_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_smp_reg   <= s1_smp_reg;
        s2_gain_reg  <= s1_gain_reg;
        s2_ramp_reg  <= ramp_next;

        s3_mode_reg  <= s2_mode_reg;
        s3_idx_reg   <= s2_idx_reg;
        s3_smp_reg   <= s2_smp_reg;
        s3_vprod_reg <= vprod_next;

        s4_mode_reg  <= s3_mode_reg;
        s4_idx_reg   <= s3_idx_reg;
        s4_smp_reg   <= s3_smp_reg;
        s4_vol_reg   <= vol_next;

        s5_mode_reg  <= s4_mode_reg;
        s5_idx_reg   <= s4_idx_reg;
        s5_cprod_reg <= cprod_next;

        s6_idx_reg   <= s5_idx_reg;
        s6_entry_reg <= old_entry;

        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;

        out_index_reg <= 10'(s6_idx_reg);
        out_left_reg  <= round_emit(s6_entry_reg[0]);
        out_right_reg <= round_emit(s6_entry_reg[1]);
    end

    // mix memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mix_l_mem[wr_addr] <= wr_data[0];
            mix_r_mem[wr_addr] <= wr_data[1];
        end
        mem_q_reg[0] <= mix_l_mem[s4_idx_reg];
        mem_q_reg[1] <= mix_r_mem[s4_idx_reg];
    end

`ifndef SYNTH
    a_no_result_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !out_valid_reg && !s5_valid_reg)
        else $error("pipeline active during clearing pass");

    a_emit_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_mode_reg == MODE_EMIT) |-> ##6 out_valid_reg)
        else $error("emit did not reach the result port");

    a_fwd_tracks_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && s5_mode_reg == MODE_ACCUM) |=>
            (fwd_valid_reg && fwd_addr_reg == $past(s5_idx_reg)))
        else $error("forwarding register missed an accumulate write");

    a_clear_sweep: assert property (
        @(posedge clk) disable iff (!rst_n)
        (clearing_reg && clr_addr_reg != AW'(DEPTH - 1)) |=>
            (clearing_reg && clr_addr_reg == $past(clr_addr_reg) + 1'b1))
        else $error("clearing pass skipped an entry");
`endif

endmodule

// ===== tb/sv/tb_stereo_voice_mix_accumulator.sv =====
`timescale 1ns / 100ps
// Self-checking bench for stereo_voice_mix_accumulator: directed table, then random
// frame slices under several gain settings. Depends on svma_pkg and the block's RTL.
module tb_stereo_voice_mix_accumulator;
    import svma_pkg::*;

    localparam mode_t  MODE_UNUSED = 2'd3;
    localparam vtype_t VTYPE_NONE  = 2'd3;

    localparam int FRAME_DEPTH   = 1024;
    localparam int SETTLE_CYCLES = 16;      // accumulates are silent
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_SHOWN     = 10;

    localparam longint I32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint I32_MIN = -64'sh0000_0000_8000_0000;

    localparam logic [30:0]        Q30_ONE  = 31'h4000_0000;
    localparam logic [30:0]        Q30_HALF = 31'h2000_0000;
    localparam logic [30:0]        Q30_TOP  = 31'h7FFF_FFFF;
    localparam logic signed [31:0] STEP_ONE = 32'sh4000_0000;
    localparam logic signed [31:0] STEP_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] STEP_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        mode_t              mode;
        logic [9:0]         idx;
        logic signed [15:0] smp_l;
        logic signed [15:0] smp_r;
        vtype_t             vtype;
        logic [30:0]        vs_l;
        logic [30:0]        vs_r;
        logic signed [31:0] st_l;
        logic signed [31:0] st_r;
    } mix_cmd_t;

    typedef struct {
        logic [9:0]         idx;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } pair_t;

    typedef struct {
        mix_cmd_t c;
        bit       fixed;
        pair_t    want;
    } table_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    mode_t              mode;
    logic [9:0]         dest_index;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    vtype_t             voice_type;
    logic [30:0]        vol_start_left;
    logic [30:0]        vol_start_right;
    logic signed [31:0] vol_step_left;
    logic signed [31:0] vol_step_right;
    logic               out_valid;
    logic [9:0]         out_index;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_idx_t           cfg_index;
    logic [15:0]        cfg_data;

    // predictor state
    logic signed [31:0] acc_left  [FRAME_DEPTH];
    logic signed [31:0] acc_right [FRAME_DEPTH];
    logic [15:0]        vol_reg   [4];

    pair_t      pending_pairs[$];
    table_row_t dir_rows[$];
    pair_t      zero_pair = '{10'd0, 16'sd0, 16'sd0};
    int         bad_results = 0;
    int         cycles = 0;

    stereo_voice_mix_accumulator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .dest_index      (dest_index),
        .sample_left     (sample_left),
        .sample_right    (sample_right),
        .voice_type      (voice_type),
        .vol_start_left  (vol_start_left),
        .vol_start_right (vol_start_right),
        .vol_step_left   (vol_step_left),
        .vol_step_right  (vol_step_right),
        .out_valid       (out_valid),
        .out_index       (out_index),
        .out_left        (out_left),
        .out_right       (out_right),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint clamp_i32(input longint x);
        if (x > I32_MAX)
            return I32_MAX;
        if (x < I32_MIN)
            return I32_MIN;
        return x;
    endfunction

    // One channel of one voice, in Q.14; shifts on signed values are floor
    function automatic longint voice_contrib(input logic [30:0] vstart,
                                             input logic signed [31:0] vstep,
                                             input logic signed [15:0] smp,
                                             input logic [9:0] idx,
                                             input longint gain);
        longint ramp;
        longint vol;
        ramp = clamp_i32(longint'(vstart) + longint'(idx) * longint'(vstep));
        vol  = clamp_i32((ramp * gain) >>> 30);
        return (vol * longint'(smp)) >>> 16;
    endfunction

    function automatic logic signed [15:0] emit_round(input logic signed [31:0] e);
        longint q;
        longint rem;
        q   = longint'(e) >>> 14;
        rem = longint'(e) - q * 16384;
        if (rem > 8192 || (rem == 8192 && q[0]))
            q++;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic void mix_apply(input mix_cmd_t c, output bit emitted, output pair_t p);
        longint g;
        emitted = 1'b0;
        p       = zero_pair;
        case (c.mode)
            MODE_CLEAR:
            begin
                acc_left[c.idx]  = 32'sd0;
                acc_right[c.idx] = 32'sd0;
            end
            MODE_ACCUM:
            begin
                case (c.vtype)
                    VTYPE_MUSIC:   g = longint'(vol_reg[CFG_MUSIC]);
                    VTYPE_EFFECTS: g = longint'(vol_reg[CFG_EFFECTS]);
                    VTYPE_UI:      g = longint'(vol_reg[CFG_UI]);
                    default:       g = 0;
                endcase
                g = g * longint'(vol_reg[CFG_MASTER]);
                acc_left[c.idx]  = 32'(clamp_i32(longint'(acc_left[c.idx])
                                   + voice_contrib(c.vs_l, c.st_l, c.smp_l, c.idx, g)));
                acc_right[c.idx] = 32'(clamp_i32(longint'(acc_right[c.idx])
                                   + voice_contrib(c.vs_r, c.st_r, c.smp_r, c.idx, g)));
            end
            MODE_EMIT:
            begin
                emitted = 1'b1;
                p.idx   = c.idx;
                p.left  = emit_round(acc_left[c.idx]);
                p.right = emit_round(acc_right[c.idx]);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic table_row_t make_row(input mode_t m, input logic [9:0] i,
                                            input logic signed [15:0] sl,
                                            input logic signed [15:0] sr,
                                            input vtype_t vt,
                                            input logic [30:0] vsl, input logic [30:0] vsr,
                                            input logic signed [31:0] stl,
                                            input logic signed [31:0] str,
                                            input bit fixed,
                                            input logic signed [15:0] wl,
                                            input logic signed [15:0] wr);
        table_row_t r;
        r.c     = '{m, i, sl, sr, vt, vsl, vsr, stl, str};
        r.fixed = fixed;
        r.want  = '{i, wl, wr};
        return r;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return $signed(16'($urandom)) >>> $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [30:0] rand_start();
        case ($urandom_range(9))
            0:       return 31'd0;
            1:       return Q30_ONE;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(0, 32'h4000_0000));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_step();
        case ($urandom_range(9))
            0:       return 32'($urandom);
            1:       return STEP_ONE;
            2:       return -STEP_ONE;
            default: return $signed(32'($urandom)) >>> $urandom_range(10, 31);
        endcase
    endfunction

    function automatic mix_cmd_t noise_cmd();
        mix_cmd_t c;
        c.mode  = mode_t'($urandom);
        c.idx   = 10'($urandom);
        c.smp_l = 16'($urandom);
        c.smp_r = 16'($urandom);
        c.vtype = vtype_t'($urandom);
        c.vs_l  = 31'($urandom);
        c.vs_r  = 31'($urandom);
        c.st_l  = 32'($urandom);
        c.st_r  = 32'($urandom);
        return c;
    endfunction

    // clear and emit carry random payload that the block must ignore
    function automatic mix_cmd_t plain_cmd(input mode_t m, input logic [9:0] i);
        mix_cmd_t c;
        c      = noise_cmd();
        c.mode = m;
        c.idx  = i;
        return c;
    endfunction

    function automatic mix_cmd_t voice_cmd(input logic [9:0] i);
        mix_cmd_t c;
        c.mode  = MODE_ACCUM;
        c.idx   = i;
        c.smp_l = rand_sample();
        c.smp_r = rand_sample();
        c.vtype = ($urandom_range(19) == 0) ? VTYPE_NONE : vtype_t'($urandom_range(0, 2));
        c.vs_l  = rand_start();
        c.vs_r  = rand_start();
        c.st_l  = rand_step();
        c.st_r  = rand_step();
        return c;
    endfunction

    task automatic send_cmd(input mix_cmd_t c, input bit fixed, input pair_t fixed_pair);
        bit    emitted;
        pair_t p;
        start           <= 1'b1;
        mode            <= c.mode;
        dest_index      <= c.idx;
        sample_left     <= c.smp_l;
        sample_right    <= c.smp_r;
        voice_type      <= c.vtype;
        vol_start_left  <= c.vs_l;
        vol_start_right <= c.vs_r;
        vol_step_left   <= c.st_l;
        vol_step_right  <= c.st_r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mix_apply(c, emitted, p);
        if (emitted)
            pending_pairs.push_back(fixed ? fixed_pair : p);
    endtask

    task automatic maybe_idle(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
    endtask

    // stop sending until every emit is back and silent accumulates have retired
    task automatic drain_pipe();
        start <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t r, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        vol_reg[r] = v;
    endtask

    task automatic set_gains(input logic [15:0] m, input logic [15:0] mu,
                             input logic [15:0] ef, input logic [15:0] ui);
        write_reg(CFG_MASTER, m);
        write_reg(CFG_MUSIC, mu);
        write_reg(CFG_EFFECTS, ef);
        write_reg(CFG_UI, ui);
        cfg_valid <= 1'b0;
    endtask

    // Mostly frame slices: clear a window, mix voices into it, emit it; some noise
    task automatic run_phase(input int items, input int pct);
        int       done_items;
        int       width;
        int       base;
        int       n;
        mix_cmd_t c;
        done_items = 0;
        while (done_items < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                c = noise_cmd();
                send_cmd(c, 1'b0, zero_pair);
                maybe_idle(pct);
                if (c.mode != MODE_UNUSED)
                    done_items++;
            end
            else
            begin
                width = $urandom_range(1, 6);
                base  = ($urandom_range(4) == 0) ? FRAME_DEPTH - width
                                                 : $urandom_range(0, FRAME_DEPTH - width);
                n     = $urandom_range(0, 3 * width + 2);
                for (int i = 0; i < width; i++)
                begin
                    send_cmd(plain_cmd(MODE_CLEAR, 10'(base + i)), 1'b0, zero_pair);
                    maybe_idle(pct);
                end
                repeat (n)
                begin
                    send_cmd(voice_cmd(10'(base + $urandom_range(0, width - 1))),
                             1'b0, zero_pair);
                    maybe_idle(pct);
                end
                for (int i = 0; i < width; i++)
                begin
                    send_cmd(plain_cmd(MODE_EMIT, 10'(base + i)), 1'b0, zero_pair);
                    maybe_idle(pct);
                end
                done_items += 2 * width + n;
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pair_t want;
        if (rst_n && out_valid)
        begin
            if (pending_pairs.size() == 0)
            begin
                if (bad_results < MAX_SHOWN)
                    $display("unexpected result: idx %0d L %0d R %0d",
                             out_index, out_left, out_right);
                bad_results++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (out_index !== want.idx || out_left !== want.left
                    || out_right !== want.right)
                begin
                    if (bad_results < MAX_SHOWN)
                        $display("mismatch: expected idx %0d L %0d R %0d, got idx %0d L %0d R %0d",
                                 want.idx, want.left, want.right,
                                 out_index, out_left, out_right);
                    bad_results++;
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        mode            = MODE_CLEAR;
        dest_index      = 10'd0;
        sample_left     = 16'sd0;
        sample_right    = 16'sd0;
        voice_type      = VTYPE_MUSIC;
        vol_start_left  = 31'd0;
        vol_start_right = 31'd0;
        vol_step_left   = 32'sd0;
        vol_step_right  = 32'sd0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_MASTER;
        cfg_data        = 16'd0;
        for (int k = 0; k < FRAME_DEPTH; k++)
        begin
            acc_left[k]  = 32'sd0;
            acc_right[k] = 32'sd0;
        end
        vol_reg[CFG_MASTER]  = GAIN_UNITY;
        vol_reg[CFG_MUSIC]   = GAIN_UNITY;
        vol_reg[CFG_EFFECTS] = GAIN_UNITY;
        vol_reg[CFG_UI]      = GAIN_UNITY;

        // Directed: full-scale samples, ties to even, silent voice type, unused mode,
        // ramp saturating both ways, entry saturation, emit after clear.
        dir_rows.push_back(make_row(MODE_EMIT, 10'd0, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd1023, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 0, 0));
        dir_rows.push_back(make_row(MODE_ACCUM, 10'd0, 32767, -32768, VTYPE_MUSIC,
                                    Q30_ONE, Q30_ONE, 0, 0, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd0, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 32767, -32768));
        dir_rows.push_back(make_row(MODE_CLEAR, 10'd0, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd0, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 0, 0));
        dir_rows.push_back(make_row(MODE_ACCUM, 10'd1, 1, -1, VTYPE_EFFECTS,
                                    Q30_HALF, Q30_HALF, 0, 0, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd1, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 0, 0));
        dir_rows.push_back(make_row(MODE_ACCUM, 10'd1, 2, -2, VTYPE_UI,
                                    Q30_HALF, Q30_HALF, 0, 0, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd1, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 2, -2));
        dir_rows.push_back(make_row(MODE_ACCUM, 10'd2, 32767, 32767, VTYPE_NONE,
                                    Q30_ONE, Q30_ONE, STEP_ONE, STEP_ONE, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd2, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 0, 0));
        dir_rows.push_back(make_row(MODE_UNUSED, 10'd2, 32767, -32768, VTYPE_MUSIC,
                                    Q30_ONE, Q30_ONE, STEP_ONE, STEP_ONE, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd2, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 0, 0));
        repeat (3)
            dir_rows.push_back(make_row(MODE_ACCUM, 10'd1023, 32767, -32768, VTYPE_MUSIC,
                                        Q30_ONE, Q30_ONE, STEP_ONE, STEP_ONE, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd1023, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 32767, -32768));
        dir_rows.push_back(make_row(MODE_ACCUM, 10'd512, -32768, 12345, VTYPE_EFFECTS,
                                    Q30_ONE, 0, -STEP_ONE, STEP_MIN, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_ACCUM, 10'd512, -1, 1, VTYPE_UI,
                                    Q30_TOP, Q30_TOP, STEP_MAX, -1, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd512, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_ACCUM, 10'd3, -12345, 23456, VTYPE_MUSIC,
                                    Q30_TOP, 0, -32'sd1048576, 32'sd1048576, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd3, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_CLEAR, 10'd1023, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b0, 0, 0));
        dir_rows.push_back(make_row(MODE_EMIT, 10'd1023, 0, 0, VTYPE_MUSIC,
                                    0, 0, 0, 0, 1'b1, 0, 0));

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].want);
        drain_pipe();

        set_gains(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY);
        run_phase(200, 0);
        drain_pipe();

        set_gains(16'($urandom_range(0, 32768)), 16'd0, 16'hFFFF,
                  16'($urandom_range(0, 32768)));
        run_phase(160, 64);
        drain_pipe();

        // gains far above unity: volume and entry saturation are common here
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(160, 18);
        drain_pipe();

        set_gains(16'd0, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY);
        run_phase(80, 0);
        drain_pipe();

        set_gains(16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                  16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
        run_phase(200, 18);
        drain_pipe();

        if (bad_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
src/svma_pkg.sv
src/stereo_voice_mix_accumulator.sv
tb/sv/tb_stereo_voice_mix_accumulator.sv
